FILE: sv/ffba_pkg.sv
// ffba_pkg: shared codes and field widths for the first-fit block allocator
// used by the allocator top level and its port checker; no dependencies
`timescale 1ns / 1ps

package ffba_pkg;

	// request field widths
	localparam int FUNC_W   = 2;
	localparam int SLOT_W   = 16;
	localparam int COUNT_W  = 17;

	// configuration field widths
	localparam int CAP_W     = 17;
	localparam int STRIDE_W  = 13;
	localparam int ADDR_W    = 64;
	localparam int CFG_IDX_W = 2;

	// request function codes
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE = 2'd3;

	// configuration reset values
	localparam logic [CAP_W-1:0]    CAP_RESET    = 17'd65536;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;

endpackage

FILE: sv/ffba_free_ram.sv
// ffba_free_ram: single write port, single read port store for free-list entries
// registered read data; no reset on contents; no package dependencies
`timescale 1ns / 1ps

module ffba_free_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 34
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/first_fit_block_allocator_unit.sv
// first_fit_block_allocator_unit: first-fit free list with bump fallback
// depends on ffba_pkg and ffba_free_ram
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Free, set and
// unused requests never raise busy; their result strobes on done in the
// cycle after the request. An allocate raises busy and walks the free list
// one entry per cycle through the free-list RAM's registered read port,
// with one length compare per cycle. A hit whose block is not used up
// goes straight on to the address steps; a hit that empties its block
// first moves the later entries down one per cycle; a miss falls back
// to the bump pointer, and when the bump bound fails the result strobes
// with out_of_space set. A grant's address steps are a stride multiply
// and then the two base additions, and its strobe comes with the sums.
// done is high for one cycle only and cannot be held off,
// so results must be taken as they come; a new request may be issued in
// the same cycle that done is shown.

module first_fit_block_allocator_unit #(
	parameter int FREE_SLOTS = 64,
	parameter int INDEX_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                start,
	output logic                                busy,
	input  logic [ffba_pkg::FUNC_W-1:0]         func,
	input  logic [ffba_pkg::SLOT_W-1:0]         slot_index,
	input  logic [ffba_pkg::COUNT_W-1:0]        slot_count,
	// result channel
	output logic                                done,
	output logic [ffba_pkg::ADDR_W-1:0]         cpu_address,
	output logic [ffba_pkg::ADDR_W-1:0]         gpu_address,
	output logic [ffba_pkg::SLOT_W-1:0]         granted_index,
	output logic [ffba_pkg::COUNT_W-1:0]        granted_count,
	output logic                                out_of_space,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ffba_pkg::ADDR_W-1:0]         cfg_data
);

	localparam int LW = ffba_pkg::COUNT_W;
	localparam int XW = INDEX_BITS + 1;
	localparam int CW = (XW > ffba_pkg::CAP_W) ? XW : ffba_pkg::CAP_W;
	localparam int EW = $clog2(FREE_SLOTS + 1);
	localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int DW = XW + LW;
	localparam int PW = XW + ffba_pkg::STRIDE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_BUMP,
		S_MUL,
		S_ADD
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ffba_pkg::CAP_W-1:0]    capacity_q;
	logic [ffba_pkg::STRIDE_W-1:0] stride_q;
	logic [ffba_pkg::ADDR_W-1:0]   cpu_base_q;
	logic [ffba_pkg::ADDR_W-1:0]   gpu_base_q;

	// sequencer state
	logic [EW-1:0] ptr_q;
	logic [EW-1:0] entries_q;
	logic [XW-1:0] bump_q;
	logic [LW-1:0] cnt_q;
	logic [XW-1:0] index_q;
	logic [PW-1:0] prod_q;

	// result registers
	logic                             done_q;
	logic [ffba_pkg::ADDR_W-1:0]      cpu_address_q;
	logic [ffba_pkg::ADDR_W-1:0]      gpu_address_q;
	logic [ffba_pkg::SLOT_W-1:0]      granted_index_q;
	logic [ffba_pkg::COUNT_W-1:0]     granted_count_q;
	logic                             out_of_space_q;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [EW-1:0] rd_ptr;
	logic [DW-1:0] ram_rdata;

	// request decode
	logic          accept;
	logic [INDEX_BITS-1:0] sidx;
	logic [XW-1:0] room;
	logic [LW-1:0] free_len;
	logic          list_room;

	// scan datapath
	logic [XW-1:0] rd_start;
	logic [LW-1:0] rd_len;
	logic          hit;
	logic [LW-1:0] new_len;
	logic [XW-1:0] new_start;
	logic [EW-1:0] ptr_nxt;
	logic          more;

	// bump datapath
	logic [CW-1:0] span_c;
	logic [CW-1:0] cap_w;
	logic [CW-1:0] usable;
	logic [CW-1:0] bump_w;
	logic [CW-1:0] cnt_w;
	logic          fits;
	logic [31:0]   index_ext;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// free request: clip block to the index span
	assign sidx      = INDEX_BITS'(slot_index);
	assign room      = (XW'(1) << INDEX_BITS) - XW'(sidx);
	assign free_len  = (CW'(slot_count) < CW'(room)) ? slot_count : LW'(room);
	assign list_room = (entries_q < EW'(FREE_SLOTS));

	// first-fit compare on the entry read last cycle
	assign rd_start  = ram_rdata[DW-1:LW];
	assign rd_len    = ram_rdata[LW-1:0];
	assign hit       = (rd_len >= cnt_q);
	assign new_len   = rd_len - cnt_q;
	assign new_start = rd_start + XW'(cnt_q);
	assign ptr_nxt   = ptr_q + EW'(1);
	assign more      = (ptr_nxt < entries_q);

	// bump bound, exact fill allowed
	assign span_c = CW'(1) << INDEX_BITS;
	assign cap_w  = CW'(capacity_q);
	assign usable = (cap_w < span_c) ? cap_w : span_c;
	assign bump_w = CW'(bump_q);
	assign cnt_w  = CW'(cnt_q);
	assign fits   = (bump_w <= usable) && (cnt_w <= usable - bump_w);

	assign index_ext = 32'(index_q);

	// read address: prefetch the next entry while scanning or shifting
	always_comb begin
		case (state_q)
			S_SCAN:  rd_ptr = ptr_nxt;
			S_SHIFT: rd_ptr = ptr_q + EW'(2);
			default: rd_ptr = '0;
		endcase
	end

	// write port: append on free, update on split, move down on removal
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[AW-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			S_IDLE: begin
				ram_waddr = entries_q[AW-1:0];
				ram_wdata = {XW'(sidx), free_len};
				ram_we    = accept && (func == ffba_pkg::FUNC_FREE) &&
				            (free_len != '0) && list_room;
			end
			S_SCAN: begin
				ram_wdata = {new_start, new_len};
				ram_we    = hit && (new_len != '0);
			end
			S_SHIFT: begin
				ram_we = more;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ffba_free_ram #(
		.DEPTH (FREE_SLOTS),
		.AW    (AW),
		.DW    (DW)
	) u_free_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_ptr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= ffba_pkg::CAP_RESET;
			stride_q   <= ffba_pkg::STRIDE_RESET;
			cpu_base_q <= '0;
			gpu_base_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ffba_pkg::REG_CAPACITY: capacity_q <= cfg_data[ffba_pkg::CAP_W-1:0];
				ffba_pkg::REG_STRIDE:   stride_q   <= cfg_data[ffba_pkg::STRIDE_W-1:0];
				ffba_pkg::REG_CPU_BASE: cpu_base_q <= cfg_data;
				ffba_pkg::REG_GPU_BASE: gpu_base_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			ptr_q           <= '0;
			entries_q       <= '0;
			bump_q          <= '0;
			done_q          <= 1'b0;
			cnt_q           <= '0;
			index_q         <= '0;
			prod_q          <= '0;
			cpu_address_q   <= '0;
			gpu_address_q   <= '0;
			granted_index_q <= '0;
			granted_count_q <= '0;
			out_of_space_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= slot_count;
						ptr_q <= '0;
						case (func)
							ffba_pkg::FUNC_ALLOC: begin
								state_q <= (entries_q == '0) ? S_BUMP : S_SCAN;
							end
							ffba_pkg::FUNC_FREE: begin
								if ((free_len != '0) && list_room) begin
									entries_q <= entries_q + EW'(1);
								end
								done_q          <= 1'b1;
								cpu_address_q   <= '0;
								gpu_address_q   <= '0;
								granted_index_q <= '0;
								granted_count_q <= '0;
								out_of_space_q  <= (free_len != '0) && !list_room;
							end
							ffba_pkg::FUNC_SET: begin
								bump_q          <= XW'(sidx);
								done_q          <= 1'b1;
								cpu_address_q   <= '0;
								gpu_address_q   <= '0;
								granted_index_q <= '0;
								granted_count_q <= '0;
								out_of_space_q  <= 1'b0;
							end
							default: begin
								done_q          <= 1'b1;
								cpu_address_q   <= '0;
								gpu_address_q   <= '0;
								granted_index_q <= '0;
								granted_count_q <= '0;
								out_of_space_q  <= 1'b0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						index_q <= rd_start;
						state_q <= (new_len == '0) ? S_SHIFT : S_MUL;
					end else if (more) begin
						ptr_q <= ptr_nxt;
					end else begin
						state_q <= S_BUMP;
					end
				end
				S_SHIFT: begin
					if (more) begin
						ptr_q <= ptr_nxt;
					end else begin
						entries_q <= entries_q - EW'(1);
						state_q   <= S_MUL;
					end
				end
				S_BUMP: begin
					if (fits) begin
						index_q <= bump_q;
						bump_q  <= XW'(bump_w + cnt_w);
						state_q <= S_MUL;
					end else begin
						done_q          <= 1'b1;
						cpu_address_q   <= '0;
						gpu_address_q   <= '0;
						granted_index_q <= '0;
						granted_count_q <= '0;
						out_of_space_q  <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_MUL: begin
					prod_q  <= PW'(index_q) * PW'(stride_q);
					state_q <= S_ADD;
				end
				S_ADD: begin
					done_q          <= 1'b1;
					cpu_address_q   <= cpu_base_q + ffba_pkg::ADDR_W'(prod_q);
					gpu_address_q   <= gpu_base_q + ffba_pkg::ADDR_W'(prod_q);
					granted_index_q <= index_ext[ffba_pkg::SLOT_W-1:0];
					granted_count_q <= cnt_q;
					out_of_space_q  <= 1'b0;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign cpu_address   = cpu_address_q;
	assign gpu_address   = gpu_address_q;
	assign granted_index = granted_index_q;
	assign granted_count = granted_count_q;
	assign out_of_space  = out_of_space_q;

endmodule

FILE: sv/ffba_checker.sv
// ffba_checker: port-level checks on the first-fit block allocator over time
// depends on ffba_pkg; bound to first_fit_block_allocator_unit below
`timescale 1ns / 1ps

module ffba_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [ffba_pkg::FUNC_W-1:0]  func,
	input logic                         done,
	input logic [ffba_pkg::ADDR_W-1:0]  cpu_address,
	input logic [ffba_pkg::ADDR_W-1:0]  gpu_address,
	input logic [ffba_pkg::SLOT_W-1:0]  granted_index,
	input logic [ffba_pkg::COUNT_W-1:0] granted_count,
	input logic                         out_of_space
);

	// an allocate request always goes busy on the next cycle
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == ffba_pkg::FUNC_ALLOC) |=> busy)
		else $error("allocate request did not raise busy");

	// free and set requests answer on the next cycle without going busy
	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy &&
		((func == ffba_pkg::FUNC_FREE) || (func == ffba_pkg::FUNC_SET))
		|=> done && !busy)
		else $error("free or set request missed its one-cycle result");

	// an allocate finishes with its result strobe
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// a flagged result carries no grant
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_space |-> (cpu_address == '0) && (gpu_address == '0) &&
		(granted_index == '0) && (granted_count == '0))
		else $error("failed request carries grant fields");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);
